### hdl/link_frame_builder_macros.svh
// assertion macros for the link frame builder
`ifndef LINK_FRAME_BUILDER_MACROS_SVH
`define LINK_FRAME_BUILDER_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define LFB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("link frame builder check failed");

// condition must never be seen outside reset
`define LFB_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("link frame builder forbidden condition");

`else

`define LFB_ASSERT(label, clk, rst_n, prop)
`define LFB_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

### hdl/lfb_pkg.sv
// shared types, constants and helpers of the link frame builder
package lfb_pkg;

    localparam logic [7:0] ESC_BYTE      = 8'h7D;
    localparam logic [7:0] ESC_FLAG_CODE = 8'h5E;
    localparam logic [7:0] ESC_ESC_CODE  = 8'h5D;
    localparam logic [7:0] CTRL_SEQ1     = 8'h40;
    localparam logic [7:0] CTRL_SEQ0     = 8'h00;

    localparam logic [7:0] FLAG_RESET    = 8'h7E;
    localparam logic [7:0] ADDR_RESET    = 8'h03;

    // register index, taken from paddr[2]
    localparam logic REG_FLAG = 1'b0;
    localparam logic REG_ADDR = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    // one classified item handed from front to back
    typedef struct packed {
        logic [7:0] payload;
        logic       seq;
        logic       last;
        logic       header;
        logic [7:0] check;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [3:0] {
        ST_START,
        ST_FLAG,
        ST_ADDR,
        ST_CTRL,
        ST_HCHK,
        ST_DATA,
        ST_DATA_ESC,
        ST_CHK,
        ST_CHK_ESC,
        ST_END
    } step_t;

    function automatic logic is_special(input logic [7:0] b, input logic [7:0] flag);
        is_special = (b == flag) || (b == ESC_BYTE);
    endfunction

    // second byte of an escape pair, flag rule first
    function automatic logic [7:0] esc_code(input logic [7:0] b, input logic [7:0] flag);
        esc_code = (b == flag) ? ESC_FLAG_CODE : ESC_ESC_CODE;
    endfunction

endpackage

### hdl/lfb_front.sv
// front end: accepts payload items, tracks frame state and running check
module lfb_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_payload,
    input  logic             in_seq,
    input  logic             in_last,
    input  lfb_pkg::q_status_t q_stat,
    output logic             push,
    output lfb_pkg::cmd_t    cmd
);

    logic       inside_frame_reg;
    logic       inside_frame_next;
    logic [7:0] check_reg;
    logic [7:0] check_next;
    logic [7:0] check_sum;

    assign in_ready  = !q_stat.full;
    assign push      = in_valid && !q_stat.full;
    assign check_sum = (inside_frame_reg ? check_reg : 8'h00) ^ in_payload;

    always_comb
    begin
        cmd.payload = in_payload;
        cmd.seq     = in_seq;
        cmd.last    = in_last;
        cmd.header  = !inside_frame_reg;
        cmd.check   = check_sum;
    end

    always_comb
    begin
        inside_frame_next = inside_frame_reg;
        check_next        = check_reg;
        if (push)
        begin
            inside_frame_next = !in_last;
            check_next        = in_last ? 8'h00 : check_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_frame_reg <= 1'b0;
            check_reg        <= 8'h00;
        end
        else
        begin
            inside_frame_reg <= inside_frame_next;
            check_reg        <= check_next;
        end
    end

endmodule

### hdl/lfb_queue.sv
// short command queue between front and back
module lfb_queue #(
    parameter int DEPTH = lfb_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lfb_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output lfb_pkg::cmd_t      head,
    output lfb_pkg::q_status_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lfb_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

### hdl/lfb_back.sv
// back end: expands each command into its header, stuffed payload byte, stuffed check and closing flag as needed
module lfb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         flag_byte,
    input  logic [7:0]         address_byte,
    input  lfb_pkg::cmd_t      head,
    input  lfb_pkg::q_status_t q_stat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_data,
    output logic               out_last
);

    lfb_pkg::step_t state_reg;
    lfb_pkg::step_t state_next;
    lfb_pkg::step_t cur_step;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_data_reg;
    logic       out_last_reg;

    logic       advance;
    logic       active;
    logic       data_special;
    logic       chk_special;
    logic [7:0] ctrl_byte;
    logic [7:0] emit_byte;
    logic       emit_end;

    assign advance      = !out_valid_reg || out_ready;
    assign active       = advance && !q_stat.empty;
    assign data_special = lfb_pkg::is_special(head.payload, flag_byte);
    assign chk_special  = lfb_pkg::is_special(head.check, flag_byte);
    assign ctrl_byte    = head.seq ? lfb_pkg::CTRL_SEQ1 : lfb_pkg::CTRL_SEQ0;

    // a new command starts at its header or straight at its data
    always_comb
    begin
        if (state_reg == lfb_pkg::ST_START)
            cur_step = head.header ? lfb_pkg::ST_FLAG : lfb_pkg::ST_DATA;
        else
            cur_step = state_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        if (active)
        begin
            case (cur_step)
                lfb_pkg::ST_FLAG:     state_next = lfb_pkg::ST_ADDR;
                lfb_pkg::ST_ADDR:     state_next = lfb_pkg::ST_CTRL;
                lfb_pkg::ST_CTRL:     state_next = lfb_pkg::ST_HCHK;
                lfb_pkg::ST_HCHK:     state_next = lfb_pkg::ST_DATA;
                lfb_pkg::ST_DATA:
                begin
                    if (data_special)
                        state_next = lfb_pkg::ST_DATA_ESC;
                    else
                        state_next = head.last ? lfb_pkg::ST_CHK : lfb_pkg::ST_START;
                end
                lfb_pkg::ST_DATA_ESC:
                    state_next = head.last ? lfb_pkg::ST_CHK : lfb_pkg::ST_START;
                lfb_pkg::ST_CHK:
                    state_next = chk_special ? lfb_pkg::ST_CHK_ESC : lfb_pkg::ST_END;
                lfb_pkg::ST_CHK_ESC:  state_next = lfb_pkg::ST_END;
                lfb_pkg::ST_END:      state_next = lfb_pkg::ST_START;
                default:              state_next = lfb_pkg::ST_START;
            endcase
        end
    end

    always_comb
    begin
        emit_byte = head.payload;
        emit_end  = 1'b0;
        pop       = 1'b0;
        case (cur_step)
            lfb_pkg::ST_FLAG:     emit_byte = flag_byte;
            lfb_pkg::ST_ADDR:     emit_byte = address_byte;
            lfb_pkg::ST_CTRL:     emit_byte = ctrl_byte;
            lfb_pkg::ST_HCHK:     emit_byte = address_byte ^ ctrl_byte;
            lfb_pkg::ST_DATA:
            begin
                emit_byte = data_special ? lfb_pkg::ESC_BYTE : head.payload;
                pop       = active && !data_special && !head.last;
            end
            lfb_pkg::ST_DATA_ESC:
            begin
                emit_byte = lfb_pkg::esc_code(head.payload, flag_byte);
                pop       = active && !head.last;
            end
            lfb_pkg::ST_CHK:
                emit_byte = chk_special ? lfb_pkg::ESC_BYTE : head.check;
            lfb_pkg::ST_CHK_ESC:  emit_byte = lfb_pkg::esc_code(head.check, flag_byte);
            lfb_pkg::ST_END:
            begin
                emit_byte = flag_byte;
                emit_end  = 1'b1;
                pop       = active;
            end
            default:              emit_byte = head.payload;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfb_pkg::ST_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (active)
        begin
            out_data_reg <= emit_byte;
            out_last_reg <= emit_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

### hdl/link_frame_builder.sv
// top level of the link frame builder: config registers, front, queue and back
//
// byte-stuffing framer for serial link information frames. each input item is
// one payload byte (tdata), its frame sequence bit (tuser, only looked at on
// the first byte of a frame) and an end-of-frame mark (tlast). the first byte
// of a frame produces the flag, address, control byte and header check before
// the stuffed payload byte; the last byte is followed by the stuffed xor check
// of the frame's payload and a closing flag, which carries tlast on the output.
// an input item yields between one and nine line bytes. the back end puts out
// one line byte per clock unless m_axis_tready holds it off. the input side
// takes an item every cycle while the command queue (QUEUE_DEPTH entries) has
// room, so bursts are absorbed and the sustained rate is set by the back end's
// one-byte-per-cycle output register.
// registers: flag byte at address 0x0, address byte at 0x4; write them only
// while the block is idle
module link_frame_builder #(
    parameter int QUEUE_DEPTH = lfb_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,

    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // payload items in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
    input  logic        s_axis_tuser,   // [0] sequence_bit
    input  logic        s_axis_tlast,   // last_byte

    // line bytes out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] line_byte
    output logic        m_axis_tlast    // frame_end
);

`include "link_frame_builder_macros.svh"

    logic [7:0] flag_byte_reg;
    logic [7:0] flag_byte_next;
    logic [7:0] address_byte_reg;
    logic [7:0] address_byte_next;
    logic       cfg_write;

    lfb_pkg::cmd_t      push_cmd;
    lfb_pkg::cmd_t      head;
    lfb_pkg::q_status_t q_stat;
    logic               push;
    logic               pop;

    // configuration registers, register picked by paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        flag_byte_next    = flag_byte_reg;
        address_byte_next = address_byte_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                lfb_pkg::REG_FLAG: flag_byte_next    = pwdata[7:0];
                lfb_pkg::REG_ADDR: address_byte_next = pwdata[7:0];
                default:           flag_byte_next    = flag_byte_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            lfb_pkg::REG_FLAG: prdata = {24'h0, flag_byte_reg};
            lfb_pkg::REG_ADDR: prdata = {24'h0, address_byte_reg};
            default:           prdata = 32'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_byte_reg    <= lfb_pkg::FLAG_RESET;
            address_byte_reg <= lfb_pkg::ADDR_RESET;
        end
        else
        begin
            flag_byte_reg    <= flag_byte_next;
            address_byte_reg <= address_byte_next;
        end
    end

    // front: frame state and running check
    lfb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_payload (s_axis_tdata),
        .in_seq     (s_axis_tuser),
        .in_last    (s_axis_tlast),
        .q_stat     (q_stat),
        .push       (push),
        .cmd        (push_cmd)
    );

    // decouples input acceptance from byte expansion
    lfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    // back: one line byte per cycle into the output register, unless m_axis_tready stalls it
    lfb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .flag_byte    (flag_byte_reg),
        .address_byte (address_byte_reg),
        .head         (head),
        .q_stat       (q_stat),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .out_last     (m_axis_tlast)
    );

    // closing byte of a frame is always the delimiter
    `LFB_ASSERT(a_end_is_flag, clk, rst_n, (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == flag_byte_reg))
    // no write into a full queue, no read from an empty one
    `LFB_ASSERT_NEVER(a_push_full, clk, rst_n, push && q_stat.full)
    `LFB_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && q_stat.empty)

endmodule

### tb/tb_link_frame_builder.sv
// self-checking testbench of the link frame builder: stream stimulus, apb set-up, byte scoreboard
module tb_link_frame_builder;

    // cycles without any handshake before the run is given up
    localparam int STALL_LIMIT = 4000;
    // random part: one phase per register setting, the last one without idling
    localparam int NUM_PHASES = 6;
    localparam int PHASE_ITEMS = 70;

    // one expected or observed line byte
    typedef struct packed {
        logic [7:0] value;
        logic       frame_end;
    } line_byte_t;

    // framer prediction and the queue of line bytes still owed by the block
    class frame_scoreboard;
        logic [7:0]  flag_val;
        logic [7:0]  addr_val;
        bit          in_frame;
        logic [7:0]  xor_acc;
        line_byte_t  owed_q[$];
        int          errors;

        function new();
            flag_val = lfb_pkg::FLAG_RESET;
            addr_val = lfb_pkg::ADDR_RESET;
            in_frame = 1'b0;
            xor_acc  = 8'h00;
            errors   = 0;
        endfunction

        function void set_reg(logic idx, logic [7:0] v);
            if (idx == lfb_pkg::REG_FLAG)
                flag_val = v;
            else
                addr_val = v;
        endfunction

        function int owed();
            return owed_q.size();
        endfunction

        function void push_line(logic [7:0] v, logic e);
            line_byte_t lb;
            lb.value = v;
            lb.frame_end = e;
            owed_q.push_back(lb);
        endfunction

        // flag rule first, so a flag equal to the escape gets the flag code
        function void push_stuffed(logic [7:0] v);
            if (v == flag_val)
            begin
                push_line(lfb_pkg::ESC_BYTE, 1'b0);
                push_line(lfb_pkg::ESC_FLAG_CODE, 1'b0);
            end
            else if (v == lfb_pkg::ESC_BYTE)
            begin
                push_line(lfb_pkg::ESC_BYTE, 1'b0);
                push_line(lfb_pkg::ESC_ESC_CODE, 1'b0);
            end
            else
                push_line(v, 1'b0);
        endfunction

        // accepted payload item: work out every line byte it causes
        function void note_item(logic [7:0] d, logic s, logic l);
            logic [7:0] ctl;
            if (!in_frame)
            begin
                ctl = s ? lfb_pkg::CTRL_SEQ1 : lfb_pkg::CTRL_SEQ0;
                // header goes out unstuffed
                push_line(flag_val, 1'b0);
                push_line(addr_val, 1'b0);
                push_line(ctl, 1'b0);
                push_line(addr_val ^ ctl, 1'b0);
                in_frame = 1'b1;
                xor_acc  = 8'h00;
            end
            xor_acc = xor_acc ^ d;
            push_stuffed(d);
            if (l)
            begin
                push_stuffed(xor_acc);
                push_line(flag_val, 1'b1);
                in_frame = 1'b0;
                xor_acc  = 8'h00;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch: %s", msg);
        endtask

        task check_result(logic [7:0] v, logic e);
            line_byte_t want;
            if (owed_q.size() == 0)
                report($sformatf("line byte %02h end %0b with nothing owed", v, e));
            else
            begin
                want = owed_q.pop_front();
                if (v !== want.value)
                    report($sformatf("line byte %02h, predicted %02h", v, want.value));
                if (e !== want.frame_end)
                    report($sformatf("frame end %0b on byte %02h, predicted %0b",
                                     e, v, want.frame_end));
            end
        endtask

        task finish_check();
            if (owed_q.size() != 0)
                report($sformatf("%0d line bytes never arrived", owed_q.size()));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] payload_byte
    logic        s_axis_tuser;   // [0] sequence_bit
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] line_byte
    logic        m_axis_tlast;   // frame_end

    frame_scoreboard sb;

    // idling controls shared by the sender and the receiver, the receiver's stall count, item and watchdog counters
    int          idle_pct;
    bit          no_idle;
    int          stall_left;
    int          item_count;
    int          quiet_cycles;

    // running xor of the frame being generated, to steer the check byte
    logic [7:0]  gen_acc;
    bit          gen_open;

    link_frame_builder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // receiver: checks every accepted line byte, stalls in random bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (!no_idle && $urandom_range(99) < idle_pct)
            begin
                // start a burst of stalled cycles, this one included
                stall_left = $urandom_range(18, 0);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog: gives up once nothing has moved for too long
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // offer one payload item, maybe after a gap, and wait for its handshake
    task automatic send_item(input logic [7:0] d, input logic s, input logic l);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < idle_pct)
            gap = $urandom_range(19, 1);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= s;
        s_axis_tlast  <= l;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_item(d, s, l);
        item_count++;
    endtask

    // drop valid, then wait until the block owes nothing and has settled
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.owed() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // apb write followed back to back by a read of the same register
    task automatic reg_write(input logic idx, input logic [7:0] v);
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, v};
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, v);
        // read-back transfer
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {24'h0, v})
            sb.report($sformatf("register %0d read %08h, written %02h", idx, prdata, v));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // random payload bytes, biased towards the flag and the escape
    task automatic send_bytes(input int count, input bit close);
        logic [7:0] d;
        logic       l;
        int         r;
        for (int k = 0; k < count; k++)
        begin
            if (!gen_open)
                gen_acc = 8'h00;
            l = close && (k == count - 1);
            r = $urandom_range(99);
            if (r < 18)
                d = sb.flag_val;
            else if (r < 30)
                d = lfb_pkg::ESC_BYTE;
            else
                d = 8'($urandom_range(255));
            // now and then force the check byte onto a value that needs stuffing
            if (l && $urandom_range(99) < 30)
                d = gen_acc ^ (($urandom_range(1) == 1) ? sb.flag_val : lfb_pkg::ESC_BYTE);
            send_item(d, 1'($urandom_range(1)), l);
            gen_acc  = gen_acc ^ d;
            gen_open = !l;
        end
    endtask

    // main sequence
    initial
    begin
        logic [7:0] flag_set [NUM_PHASES];
        logic [7:0] addr_set [NUM_PHASES];
        int         pct_set  [NUM_PHASES];
        int         start_count;
        int         len;

        sb = new();
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'b000;
        pwdata        = 32'h0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        idle_pct      = 20;
        no_idle       = 1'b0;
        stall_left    = 0;
        item_count    = 0;
        gen_acc       = 8'h00;
        gen_open      = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one-byte frame of a flag, whose check is the flag too (nine bytes)
        send_item(8'h7E, 1'b1, 1'b1);
        // escape, zero and all-ones payload, sequence 0
        send_item(8'h7D, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        // check byte landing on the escape
        send_item(8'h11, 1'b0, 1'b0);
        send_item(8'h6C, 1'b1, 1'b1);
        // check byte landing on the flag
        send_item(8'h12, 1'b1, 1'b0);
        send_item(8'h6C, 1'b0, 1'b1);

        // register change in the middle of a frame; hold-off until all bytes are out
        send_item(8'h7E, 1'b0, 1'b0);
        drain();
        reg_write(lfb_pkg::REG_FLAG, lfb_pkg::ESC_BYTE);
        // flag equal to the escape: flag rule wins
        send_item(8'h7D, 1'b1, 1'b0);
        send_item(8'h7E, 1'b0, 1'b1);
        drain();
        reg_write(lfb_pkg::REG_FLAG, lfb_pkg::FLAG_RESET);

        // header bytes equal to flag or escape are left unstuffed
        reg_write(lfb_pkg::REG_ADDR, 8'h7E);
        send_item(8'h7D, 1'b1, 1'b1);
        drain();
        reg_write(lfb_pkg::REG_ADDR, 8'h7D);
        send_item(8'h55, 1'b0, 1'b1);
        send_item(8'h3D, 1'b1, 1'b1);
        drain();

        // random phases, each with its own register setting and idling rate
        flag_set = '{8'h7E, 8'h7D, 8'h00, 8'hFF, 8'h00, 8'h7E};
        addr_set = '{8'h03, 8'hFF, 8'h00, 8'h7D, 8'h00, 8'h7E};
        pct_set  = '{30, 10, 50, 0, 25, 0};
        flag_set[4] = 8'($urandom_range(255));
        addr_set[4] = 8'($urandom_range(255));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            reg_write(lfb_pkg::REG_FLAG, flag_set[p]);
            reg_write(lfb_pkg::REG_ADDR, addr_set[p]);
            idle_pct = pct_set[p];
            no_idle  = (p == NUM_PHASES - 1);
            start_count = item_count;
            while (item_count - start_count < PHASE_ITEMS)
            begin
                if ($urandom_range(9) == 0)
                    len = $urandom_range(40, 10);
                else
                    len = $urandom_range(6, 1);
                send_bytes(len, 1'b1);
            end
            // sometimes leave a frame open across the next register change
            if (p < NUM_PHASES - 1 && $urandom_range(1) == 1)
                send_bytes($urandom_range(3, 1), 1'b0);
        end

        // all stimulus accepted: wait out every owed byte plus a margin
        drain();
        sb.finish_check();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
